// ===== sv/lrs_pkg.sv =====
// Shared types and constants for the line raster stepper.
`default_nettype none

package lrs_pkg;

   localparam int COORD_BITS = 6;
   localparam int ERR_BITS   = COORD_BITS + 3;
   localparam int DATA_BITS  = ((2 * COORD_BITS + 7) / 8) * 8;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SETUP,
      ST_RUN
   } state_type;

   typedef enum logic {
      ACT_MOVE = 1'b0,
      ACT_DRAW = 1'b1
   } action_type;

   // Bresenham walker state: major coord, minor coord, decision term.
   typedef struct packed {
      logic [COORD_BITS-1:0] maj;
      logic [COORD_BITS-1:0] mnr;
      logic [ERR_BITS-1:0]   err;
   } step_type;

   // Per-line constants loaded at setup.
   typedef struct packed {
      logic [ERR_BITS-1:0] inc_lo;
      logic [ERR_BITS-1:0] inc_hi;
      logic                mnr_neg;
   } step_ctl_type;

endpackage

`default_nettype wire

// ===== sv/line_raster_stepper_core.sv =====
// Top level of the line raster stepper: pen point, line setup and pixel sequencer.
// Move: loads the pen point, stays idle and ready, no output.
// Draw: a setup state, then one pixel per cycle into the output register while
//   the sink accepts; a line of L pixels (major-axis length + 1) holds req_tready
//   low through setup and until the last pixel is registered. The first pixel goes
//   via setup and run states into the output register; the step unit sets the rate.
// Synchronous active-high reset: pen point to (0,0), sequencer idle, no output.
`default_nettype none

module line_raster_stepper_core
   import lrs_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   // input channel
   input  wire logic                 req_tvalid,
   output      logic                 req_tready,
   input  wire logic [DATA_BITS-1:0] req_tdata,   // target_x, target_y, zero pad
   input  wire logic                 req_tuser,   // action (0 move, 1 draw)
   // result channel
   output      logic                 rsp_tvalid,
   input  wire logic                 rsp_tready,
   output      logic [DATA_BITS-1:0] rsp_tdata,   // pixel_x, pixel_y, zero pad
   output      logic                 rsp_tlast    // last_pixel
);

   localparam int CW = COORD_BITS;
   localparam int EW = ERR_BITS;

   state_type      state_ff, state_in;
   logic [CW-1:0]  pen_x_ff, pen_x_in;
   logic [CW-1:0]  pen_y_ff, pen_y_in;
   logic [CW-1:0]  bx_ff, bx_in;        // latched target
   logic [CW-1:0]  by_ff, by_in;
   step_type       step_ff, step_in;    // walker position and decision term
   step_ctl_type   ctl_ff, ctl_in;
   logic [CW-1:0]  end_ff, end_in;      // major coordinate of the final pixel
   logic           maj_x_ff, maj_x_in;  // x is the major axis
   logic           rsp_valid_ff, rsp_valid_in;
   logic [CW-1:0]  rsp_x_ff, rsp_x_in;
   logic [CW-1:0]  rsp_y_ff, rsp_y_in;
   logic           rsp_last_ff, rsp_last_in;

   step_type       step_nxt;

   // setup terms
   logic [CW-1:0]  dx, dy, dmaj, dmin;
   logic           maj_x, swap;
   logic [CW-1:0]  start_x, start_y, start_maj, start_mnr, other_mnr, end_maj;
   logic [EW-1:0]  dmaj2, dmin2;

   logic           req_xfer, out_free, is_last;

   assign req_xfer = req_tvalid && req_tready;
   assign out_free = !rsp_valid_ff || rsp_tready;
   assign is_last  = (step_ff.maj == end_ff);

   lrs_step_unit u_step (
      .cur (step_ff),
      .ctl (ctl_ff),
      .nxt (step_nxt)
   );

   // line setup from pen (start) and latched target (end)
   always_comb begin
      dx    = (pen_x_ff > bx_ff) ? (pen_x_ff - bx_ff) : (bx_ff - pen_x_ff);
      dy    = (pen_y_ff > by_ff) ? (pen_y_ff - by_ff) : (by_ff - pen_y_ff);
      // ties go to y; axis-aligned lines fall out of the same walk
      maj_x = (dx > dy);
      dmaj  = maj_x ? dx : dy;
      dmin  = maj_x ? dy : dx;
      swap  = maj_x ? (pen_x_ff > bx_ff) : (pen_y_ff > by_ff);
      start_x = swap ? bx_ff : pen_x_ff;
      start_y = swap ? by_ff : pen_y_ff;
      start_maj = maj_x ? start_x : start_y;
      start_mnr = maj_x ? start_y : start_x;
      if (maj_x) begin
         other_mnr = swap ? pen_y_ff : by_ff;
         end_maj   = swap ? pen_x_ff : bx_ff;
      end else begin
         other_mnr = swap ? pen_x_ff : bx_ff;
         end_maj   = swap ? pen_y_ff : by_ff;
      end
      dmaj2 = EW'({dmaj, 1'b0});
      dmin2 = EW'({dmin, 1'b0});
   end

   always_comb begin
      state_in     = state_ff;
      pen_x_in     = pen_x_ff;
      pen_y_in     = pen_y_ff;
      bx_in        = bx_ff;
      by_in        = by_ff;
      step_in      = step_ff;
      ctl_in       = ctl_ff;
      end_in       = end_ff;
      maj_x_in     = maj_x_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_x_in     = rsp_x_ff;
      rsp_y_in     = rsp_y_ff;
      rsp_last_in  = rsp_last_ff;
      req_tready   = 1'b0;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_xfer) begin
               bx_in = req_tdata[CW-1:0];
               by_in = req_tdata[2*CW-1:CW];
               if (action_type'(req_tuser) == ACT_DRAW) begin
                  state_in = ST_SETUP;
               end else begin
                  pen_x_in = req_tdata[CW-1:0];
                  pen_y_in = req_tdata[2*CW-1:CW];
               end
            end
         end
         ST_SETUP: begin
            step_in.maj    = start_maj;
            step_in.mnr    = start_mnr;
            step_in.err    = dmin2 - EW'(dmaj);
            ctl_in.inc_lo  = dmin2;
            ctl_in.inc_hi  = dmin2 - dmaj2;
            ctl_in.mnr_neg = (other_mnr < start_mnr);
            end_in         = end_maj;
            maj_x_in       = maj_x;
            pen_x_in       = bx_ff;
            pen_y_in       = by_ff;
            state_in       = ST_RUN;
         end
         ST_RUN: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_x_in     = maj_x_ff ? step_ff.maj : step_ff.mnr;
               rsp_y_in     = maj_x_ff ? step_ff.mnr : step_ff.maj;
               rsp_last_in  = is_last;
               step_in      = step_nxt;
               if (is_last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pen_x_ff     <= '0;
         pen_y_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pen_x_ff     <= pen_x_in;
         pen_y_ff     <= pen_y_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      bx_ff       <= bx_in;
      by_ff       <= by_in;
      step_ff     <= step_in;
      ctl_ff      <= ctl_in;
      end_ff      <= end_in;
      maj_x_ff    <= maj_x_in;
      rsp_x_ff    <= rsp_x_in;
      rsp_y_ff    <= rsp_y_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = DATA_BITS'({rsp_y_ff, rsp_x_ff});

   // a draw transfer always goes through setup
   assert property (@(posedge clock) disable iff (reset)
      (req_xfer && req_tuser) |=> (state_ff == ST_SETUP))
      else $error("draw transfer did not enter setup");

   // a move loads the pen and stays idle
   assert property (@(posedge clock) disable iff (reset)
      (req_xfer && !req_tuser) |=>
         (state_ff == ST_IDLE) && (pen_x_ff == $past(req_tdata[CW-1:0]))
         && (pen_y_ff == $past(req_tdata[2*CW-1:CW])))
      else $error("move did not load pen point");

   // the walker never passes the line end
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RUN) |-> (step_ff.maj <= end_ff))
      else $error("walker overran line end");

   // a non-final pixel keeps the sequencer running
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RUN && out_free && !is_last) |=> (state_ff == ST_RUN))
      else $error("sequencer left run before last pixel");

   // the final pixel of a line is flagged last
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RUN && out_free && is_last) |=> (rsp_tvalid && rsp_tlast))
      else $error("last pixel not flagged");

endmodule

`default_nettype wire

// ===== sv/lrs_step_unit.sv =====
// Stepping unit: one Bresenham advance of the decision term and coordinates.
`default_nettype none

module lrs_step_unit
   import lrs_pkg::*;
(
   input  step_type     cur,
   input  step_ctl_type ctl,
   output step_type     nxt
);

   always_comb begin
      nxt     = cur;
      nxt.maj = cur.maj + COORD_BITS'(1);
      if (cur.err[ERR_BITS-1]) begin
         nxt.err = cur.err + ctl.inc_lo;
      end else begin
         nxt.mnr = ctl.mnr_neg ? (cur.mnr - COORD_BITS'(1)) : (cur.mnr + COORD_BITS'(1));
         nxt.err = cur.err + ctl.inc_hi;
      end
   end

endmodule

`default_nettype wire
